[hw/rtl/head_nod_shake_detector_unit_macros.svh]
// Assertion macros shared by the head nod and shake detector RTL.
`ifndef HEAD_NOD_SHAKE_DETECTOR_UNIT_MACROS_SVH
`define HEAD_NOD_SHAKE_DETECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define HNSD_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hnsd: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define HNSD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hnsd: next-cycle check failed");

`else

`define HNSD_ASSERT_NOW(label, pre, post)
`define HNSD_ASSERT_NEXT(label, pre, post)

`endif

`endif

[hw/rtl/hnsd_pkg.sv]
// Shared types and constants of the head nod and shake detector.
`default_nettype none

package hnsd_pkg;

    // Detection outcome as reported in every result.
    typedef enum logic [2:0] {
        OUT_RUNNING   = 3'd0,
        OUT_NOD       = 3'd1,
        OUT_SHAKE     = 3'd2,
        OUT_TO_ACCEPT = 3'd3,
        OUT_TO_REJECT = 3'd4
    } outcome_t;

    // Request kinds carried in the low bits of the slave tuser.
    localparam logic [1:0] ACT_FRAME   = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_MIN_DISTANCE  = 2'd0;
    localparam logic [1:0] REG_MIN_DIRS      = 2'd1;
    localparam logic [1:0] REG_TIMEOUT       = 2'd2;
    localparam logic [1:0] REG_FAIL_SAFE     = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [15:0] MIN_DISTANCE_RST = 16'd96;
    localparam logic [3:0]  MIN_DIRS_RST     = 4'd2;
    localparam logic [7:0]  TIMEOUT_RST      = 8'd4;
    localparam logic        FAIL_SAFE_RST    = 1'b1;

    // Percent scale times the 4 fraction bits of the threshold, times 2
    // for the averaged span: 100 * 16 * 2.
    localparam int THRESH_SCALE = 3200;

    // Smallest span sum used in the threshold product.
    localparam int MIN_SPAN_SUM = 2;

    localparam int SWING_W     = 4;
    localparam int ELAPSED_W   = 8;
    localparam int OUT_TDATA_W = 16;

endpackage

`default_nettype wire

[hw/rtl/head_nod_shake_detector_unit.sv]
// Head nod and shake detector: stream in, stream out, APB register port.
`default_nettype none

`include "head_nod_shake_detector_unit_macros.svh"

// Each request on the slave stream is a landmark frame, a time tick or a
// restart, and each one produces exactly one result on the master stream
// carrying the current outcome and the number of alternating swings seen
// on each axis. A frame with exactly one face compares the nose travel
// since the previous frame with a threshold given in percent of the eye
// span averaged over two frames; the test is cross-multiplied, so there is
// no divider. A swing is counted when its direction differs from the last
// one counted on that axis. The horizontal axis is tested first: enough
// swings there abort (shake); enough on the vertical axis confirm (nod).
// Ticks advance a timeout whose outcome follows fail_safe. Once decided,
// the outcome and counts hold until a restart request.
// Rate: the block takes one request per clock cycle for as long as the
// master side accepts results. An accepted request is held in the input
// register, and the detector state update is computed from it. The state
// register is itself the result register; it is loaded from that update
// when the held request moves on, which needs the result register to be
// empty or its result to be taken, and the result is then offered on the
// master stream. The combinational state update (two constant multiplies,
// one 16 by COORD_BITS+1 multiply and a compare per axis) is what sets the
// cycle time. A stalled master holds one result and one waiting request,
// after which s_axis_tready drops.
// Registers (32-bit APB, byte addresses): 0x0 min_distance_q4, 0x4 swings
// needed to decide, 0x8 timeout_ticks, 0xC fail_safe. Write them only while
// no request is in flight.
module head_nod_shake_detector_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [COORD_BITS-1:0] eye_a_x, then eye_b_x, nose_x, nose_y, zero padding
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] action, [2] one_face
    input  wire logic [2:0]                        s_axis_tuser,

    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] outcome, [6:3] swings_x, [10:7] swings_y, [15:11] zero
    output      logic [hnsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hnsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [hnsd_pkg::APB_DATA_W-1:0]   pwdata,
    output      logic [hnsd_pkg::APB_DATA_W-1:0]   prdata,
    output      logic                              pready
);

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int SUM_W  = COORD_BITS + 2;
    localparam int EFF_W  = COORD_BITS + 1;
    localparam int PROD_W = 16 + EFF_W;

    typedef struct packed {
        logic [hnsd_pkg::SWING_W-1:0] count;
        logic                         dir;
    } axis_state_t;

    // Configuration registers.
    logic [15:0] min_distance_reg;
    logic [3:0]  min_dirs_reg;
    logic [7:0]  timeout_reg;
    logic        fail_safe_reg;

    // Input register.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [1:0]            action_reg;
    logic                  one_face_reg;
    logic [COORD_BITS-1:0] eye_a_reg;
    logic [COORD_BITS-1:0] eye_b_reg;
    logic [COORD_BITS-1:0] nose_x_reg;
    logic [COORD_BITS-1:0] nose_y_reg;

    // Detector state, which is also the result register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [SPAN_W-1:0] prev_span_reg;
    logic signed [SPAN_W-1:0] prev_span_next;
    logic                     have_prev_reg;
    logic                     have_prev_next;
    logic [COORD_BITS-1:0]    prev_nose_x_reg;
    logic [COORD_BITS-1:0]    prev_nose_x_next;
    logic [COORD_BITS-1:0]    prev_nose_y_reg;
    logic [COORD_BITS-1:0]    prev_nose_y_next;
    axis_state_t              axis_x_reg;
    axis_state_t              axis_x_next;
    axis_state_t              axis_y_reg;
    axis_state_t              axis_y_next;
    logic [hnsd_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [hnsd_pkg::ELAPSED_W-1:0] elapsed_next;
    hnsd_pkg::outcome_t       outcome_reg;
    hnsd_pkg::outcome_t       outcome_next;

    logic                     s_accept;
    logic                     advance;
    logic                     cfg_write;
    logic [1:0]               cfg_index;

    logic signed [SPAN_W-1:0] span;
    logic signed [SUM_W-1:0]  span_sum;
    logic [EFF_W-1:0]         span_eff;
    logic [PROD_W-1:0]        rhs;
    logic [COORD_BITS-1:0]    base_x;
    logic [COORD_BITS-1:0]    base_y;
    logic signed [SPAN_W-1:0] dx;
    logic signed [SPAN_W-1:0] dy;
    axis_state_t              eval_x;
    axis_state_t              eval_y;
    logic                     decide_x;
    logic                     decide_y;
    logic [hnsd_pkg::ELAPSED_W-1:0] elapsed_inc;
    hnsd_pkg::outcome_t       timeout_code;

    // One axis: a travel whose scaled size beats the threshold product is a
    // swing, and it is counted when its sign differs from the last one.
    function automatic axis_state_t axis_eval(
        input logic signed [SPAN_W-1:0] d,
        input logic [PROD_W-1:0]        thresh,
        input axis_state_t              cur
    );
        logic                  neg;
        logic [COORD_BITS-1:0] mag;
        logic [PROD_W-1:0]     lhs;
        axis_state_t           res;
        neg = d[SPAN_W-1];
        mag = neg ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
        lhs = PROD_W'(mag) * PROD_W'(hnsd_pkg::THRESH_SCALE);
        res = cur;
        if ((lhs > thresh) && ((cur.count == '0) || (cur.dir != neg)))
        begin
            if (cur.count != '1)
            begin
                res.count = cur.count + 1'b1;
            end
            res.dir = neg;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, axis_y_reg.count, axis_x_reg.count, outcome_reg};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_index)
            hnsd_pkg::REG_MIN_DISTANCE: prdata = {16'b0, min_distance_reg};
            hnsd_pkg::REG_MIN_DIRS:     prdata = {28'b0, min_dirs_reg};
            hnsd_pkg::REG_TIMEOUT:      prdata = {24'b0, timeout_reg};
            hnsd_pkg::REG_FAIL_SAFE:    prdata = {31'b0, fail_safe_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= hnsd_pkg::MIN_DISTANCE_RST;
            min_dirs_reg     <= hnsd_pkg::MIN_DIRS_RST;
            timeout_reg      <= hnsd_pkg::TIMEOUT_RST;
            fail_safe_reg    <= hnsd_pkg::FAIL_SAFE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hnsd_pkg::REG_MIN_DISTANCE: min_distance_reg <= pwdata[15:0];
                hnsd_pkg::REG_MIN_DIRS:     min_dirs_reg     <= pwdata[3:0];
                hnsd_pkg::REG_TIMEOUT:      timeout_reg      <= pwdata[7:0];
                hnsd_pkg::REG_FAIL_SAFE:    fail_safe_reg    <= pwdata[0];
                default:                    min_dirs_reg     <= min_dirs_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Frame arithmetic
    // ---------------------------------------------------------------
    // Eye span of this frame, and the sum with the previous span, which is
    // twice the averaged span; it is clamped to at least two.
    assign span     = $signed({1'b0, eye_a_reg}) - $signed({1'b0, eye_b_reg});
    assign span_sum = $signed({prev_span_reg[SPAN_W-1], prev_span_reg})
                    + $signed({span[SPAN_W-1], span});
    assign span_eff = (span_sum < $signed(SUM_W'(hnsd_pkg::MIN_SPAN_SUM)))
                    ? EFF_W'(hnsd_pkg::MIN_SPAN_SUM) : span_sum[EFF_W-1:0];
    assign rhs      = PROD_W'(min_distance_reg) * PROD_W'(span_eff);

    // On the first frame after a restart the nose is its own reference.
    assign base_x   = have_prev_reg ? prev_nose_x_reg : nose_x_reg;
    assign base_y   = have_prev_reg ? prev_nose_y_reg : nose_y_reg;
    assign dx       = $signed({1'b0, nose_x_reg}) - $signed({1'b0, base_x});
    assign dy       = $signed({1'b0, nose_y_reg}) - $signed({1'b0, base_y});

    assign eval_x   = axis_eval(dx, rhs, axis_x_reg);
    assign eval_y   = axis_eval(dy, rhs, axis_y_reg);
    assign decide_x = eval_x.count >= min_dirs_reg;
    assign decide_y = eval_y.count >= min_dirs_reg;

    assign elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign timeout_code = fail_safe_reg ? hnsd_pkg::OUT_TO_REJECT
                                        : hnsd_pkg::OUT_TO_ACCEPT;

    // ---------------------------------------------------------------
    // Detector state update
    // ---------------------------------------------------------------
    always_comb
    begin
        prev_span_next   = prev_span_reg;
        have_prev_next   = have_prev_reg;
        prev_nose_x_next = prev_nose_x_reg;
        prev_nose_y_next = prev_nose_y_reg;
        axis_x_next      = axis_x_reg;
        axis_y_next      = axis_y_reg;
        elapsed_next     = elapsed_reg;
        outcome_next     = outcome_reg;

        if (advance)
        begin
            case (action_reg)
                hnsd_pkg::ACT_RESTART:
                begin
                    prev_span_next   = '1;
                    have_prev_next   = 1'b0;
                    prev_nose_x_next = '0;
                    prev_nose_y_next = '0;
                    axis_x_next      = '0;
                    axis_y_next      = '0;
                    elapsed_next     = '0;
                    outcome_next     = (timeout_reg == '0) ? timeout_code
                                                           : hnsd_pkg::OUT_RUNNING;
                end
                hnsd_pkg::ACT_TICK:
                begin
                    if (outcome_reg == hnsd_pkg::OUT_RUNNING)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_reg)
                        begin
                            outcome_next = timeout_code;
                        end
                    end
                end
                hnsd_pkg::ACT_FRAME:
                begin
                    if (outcome_reg == hnsd_pkg::OUT_RUNNING)
                    begin
                        if (elapsed_reg >= timeout_reg)
                        begin
                            outcome_next = timeout_code;
                        end
                        else if (one_face_reg)
                        begin
                            have_prev_next   = 1'b1;
                            axis_x_next      = eval_x;
                            prev_nose_x_next = base_x;
                            prev_nose_y_next = base_y;
                            if (decide_x)
                            begin
                                outcome_next = hnsd_pkg::OUT_SHAKE;
                            end
                            else
                            begin
                                prev_nose_x_next = nose_x_reg;
                                axis_y_next      = eval_y;
                                if (decide_y)
                                begin
                                    outcome_next = hnsd_pkg::OUT_NOD;
                                end
                                else
                                begin
                                    prev_nose_y_next = nose_y_reg;
                                    prev_span_next   = span;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    outcome_next = outcome_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            action_reg   <= s_axis_tuser[1:0];
            one_face_reg <= s_axis_tuser[2];
            eye_a_reg    <= s_axis_tdata[COORD_BITS-1:0];
            eye_b_reg    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            nose_x_reg   <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            nose_y_reg   <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_span_reg   <= '1;
            have_prev_reg   <= 1'b0;
            prev_nose_x_reg <= '0;
            prev_nose_y_reg <= '0;
            axis_x_reg      <= '0;
            axis_y_reg      <= '0;
            elapsed_reg     <= '0;
            outcome_reg     <= hnsd_pkg::OUT_RUNNING;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            prev_span_reg   <= prev_span_next;
            have_prev_reg   <= have_prev_next;
            prev_nose_x_reg <= prev_nose_x_next;
            prev_nose_y_reg <= prev_nose_y_next;
            axis_x_reg      <= axis_x_next;
            axis_y_reg      <= axis_y_next;
            elapsed_reg     <= elapsed_next;
            outcome_reg     <= outcome_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A decided outcome holds until a restart request is processed.
    `HNSD_ASSERT_NEXT(a_outcome_holds, advance && (outcome_reg != hnsd_pkg::OUT_RUNNING) && (action_reg != hnsd_pkg::ACT_RESTART), outcome_reg == $past(outcome_reg))

    // Swing counts only grow between restarts.
    `HNSD_ASSERT_NEXT(a_count_grows, advance && (action_reg != hnsd_pkg::ACT_RESTART), (axis_x_reg.count >= $past(axis_x_reg.count)) && (axis_y_reg.count >= $past(axis_y_reg.count)))

    // A restart with a non-zero timeout leaves a clean running state.
    `HNSD_ASSERT_NEXT(a_restart_clears, advance && (action_reg == hnsd_pkg::ACT_RESTART) && (timeout_reg != '0), (outcome_reg == hnsd_pkg::OUT_RUNNING) && (axis_x_reg == '0) && (axis_y_reg == '0) && (elapsed_reg == '0))

    // A held request that cannot move on blocks the slave side.
    `HNSD_ASSERT_NOW(a_full_blocks, in_valid_reg && !advance, !s_axis_tready)

endmodule

`default_nettype wire

[dv/hnsd_outcome_checker.sv]
`timescale 1ns / 100ps
// Checker for the head nod and shake detector: predicts every result and compares it.
module hnsd_outcome_checker #(
    parameter int COORD_BITS = 12,
    parameter int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [TDATA_W-1:0]              s_axis_tdata,
    input  logic [2:0]                      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [hnsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hnsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hnsd_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              results_awaited
);

    typedef struct packed {
        logic [hnsd_pkg::SWING_W-1:0] count;
        logic                         neg;
    } swing_t;

    typedef struct packed {
        hnsd_pkg::outcome_t           outcome;
        logic [hnsd_pkg::SWING_W-1:0] swings_x;
        logic [hnsd_pkg::SWING_W-1:0] swings_y;
    } detector_report_t;

    // Register copies, written from the observed APB traffic.
    logic [15:0]                    thresh_q4;
    logic [3:0]                     dirs_needed;
    logic [hnsd_pkg::ELAPSED_W-1:0] tick_limit;
    logic                           reject_on_timeout;

    // Detector state.
    logic signed [13:0]             last_span;
    logic                           seen_frame;
    logic [COORD_BITS-1:0]          last_nose_x;
    logic [COORD_BITS-1:0]          last_nose_y;
    swing_t                         track_x;
    swing_t                         track_y;
    logic [hnsd_pkg::ELAPSED_W-1:0] ticks_seen;
    hnsd_pkg::outcome_t             verdict;

    detector_report_t expected_reports[$];
    detector_report_t seen_report;
    detector_report_t oldest_report;
    detector_report_t next_report;
    int               error_total;

    task automatic clear_detection_state();
        last_span   = -14'sd1;
        seen_frame  = 1'b0;
        last_nose_x = '0;
        last_nose_y = '0;
        track_x     = '0;
        track_y     = '0;
        ticks_seen  = '0;
        verdict     = hnsd_pkg::OUT_RUNNING;
    endtask

    // Cross-multiplied threshold test on one axis.
    function automatic swing_t judge_axis(input int travel, input int span_sum,
                                          input swing_t cur);
        longint mag;
        longint lhs;
        longint rhs;
        swing_t res;
        res = cur;
        mag = (travel < 0) ? -travel : travel;
        lhs = mag * hnsd_pkg::THRESH_SCALE;
        rhs = longint'(thresh_q4) * span_sum;
        if (lhs > rhs) begin
            if (res.count == '0 || res.neg != (travel < 0)) begin
                if (res.count != 4'hF)
                    res.count = res.count + 4'd1;
                res.neg = (travel < 0);
            end
        end
        return res;
    endfunction

    task automatic advance_gesture_state(input logic [1:0] act, input logic face,
                                         input logic [4*COORD_BITS-1:0] coords);
        int ea;
        int eb;
        int nx;
        int ny;
        int span;
        int span_sum;
        ea = coords[COORD_BITS-1:0];
        eb = coords[2*COORD_BITS-1:COORD_BITS];
        nx = coords[3*COORD_BITS-1:2*COORD_BITS];
        ny = coords[4*COORD_BITS-1:3*COORD_BITS];
        if (act == hnsd_pkg::ACT_RESTART) begin
            clear_detection_state();
            if (tick_limit == '0)
                verdict = reject_on_timeout ? hnsd_pkg::OUT_TO_REJECT
                                            : hnsd_pkg::OUT_TO_ACCEPT;
        end else if (verdict == hnsd_pkg::OUT_RUNNING) begin
            if (act == hnsd_pkg::ACT_TICK) begin
                if (ticks_seen != '1)
                    ticks_seen = ticks_seen + 1'b1;
                if (ticks_seen >= tick_limit)
                    verdict = reject_on_timeout ? hnsd_pkg::OUT_TO_REJECT
                                                : hnsd_pkg::OUT_TO_ACCEPT;
            end else if (act == hnsd_pkg::ACT_FRAME) begin
                if (ticks_seen >= tick_limit) begin
                    verdict = reject_on_timeout ? hnsd_pkg::OUT_TO_REJECT
                                                : hnsd_pkg::OUT_TO_ACCEPT;
                end else if (face) begin
                    span     = ea - eb;
                    span_sum = int'(last_span) + span;
                    if (span_sum < hnsd_pkg::MIN_SPAN_SUM)
                        span_sum = hnsd_pkg::MIN_SPAN_SUM;
                    // The first frame after a restart sets the reference position.
                    if (!seen_frame) begin
                        last_nose_x = COORD_BITS'(nx);
                        last_nose_y = COORD_BITS'(ny);
                        seen_frame  = 1'b1;
                    end
                    track_x = judge_axis(nx - int'(last_nose_x), span_sum, track_x);
                    if (track_x.count >= dirs_needed) begin
                        verdict = hnsd_pkg::OUT_SHAKE;
                    end else begin
                        last_nose_x = COORD_BITS'(nx);
                        track_y = judge_axis(ny - int'(last_nose_y), span_sum, track_y);
                        if (track_y.count >= dirs_needed) begin
                            verdict = hnsd_pkg::OUT_NOD;
                        end else begin
                            last_nose_y = COORD_BITS'(ny);
                            last_span   = span[13:0];
                        end
                    end
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thresh_q4         = hnsd_pkg::MIN_DISTANCE_RST;
            dirs_needed       = hnsd_pkg::MIN_DIRS_RST;
            tick_limit        = hnsd_pkg::TIMEOUT_RST;
            reject_on_timeout = hnsd_pkg::FAIL_SAFE_RST;
            clear_detection_state();
            expected_reports.delete();
            error_total = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[hnsd_pkg::APB_ADDR_W-1:2])
                    hnsd_pkg::REG_MIN_DISTANCE: thresh_q4   = pwdata[15:0];
                    hnsd_pkg::REG_MIN_DIRS:     dirs_needed = pwdata[3:0];
                    hnsd_pkg::REG_TIMEOUT:
                        tick_limit = pwdata[hnsd_pkg::ELAPSED_W-1:0];
                    hnsd_pkg::REG_FAIL_SAFE:    reject_on_timeout = pwdata[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen_report.outcome  = hnsd_pkg::outcome_t'(m_axis_tdata[2:0]);
                seen_report.swings_x = m_axis_tdata[6:3];
                seen_report.swings_y = m_axis_tdata[10:7];
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got 0x%0h",
                             $time, m_axis_tdata);
                    error_total++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    compare_field("outcome", 4'(oldest_report.outcome),
                                  4'(seen_report.outcome));
                    compare_field("swings_x", oldest_report.swings_x, seen_report.swings_x);
                    compare_field("swings_y", oldest_report.swings_y, seen_report.swings_y);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_gesture_state(s_axis_tuser[1:0], s_axis_tuser[2],
                                      s_axis_tdata[4*COORD_BITS-1:0]);
                next_report.outcome  = verdict;
                next_report.swings_x = track_x.count;
                next_report.swings_y = track_y.count;
                expected_reports.insert(expected_reports.size(), next_report);
            end
        end
        mismatches      <= error_total;
        results_awaited <= expected_reports.size();
    end

endmodule

[dv/tb_head_nod_shake_detector_unit.sv]
`timescale 1ns / 100ps
// Top of the head nod and shake detector testbench: stimulus, receiver and verdict.
module tb_head_nod_shake_detector_unit;

    localparam int COORD_BITS = 12;
    localparam int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int ADDR_W     = hnsd_pkg::APB_ADDR_W;
    localparam int DATA_W     = hnsd_pkg::APB_DATA_W;
    localparam int RES_W      = hnsd_pkg::OUT_TDATA_W;
    // The block ignores this request kind but still answers it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Requests given to each random phase, and the number of phases.
    localparam int PHASE_REQUESTS = 162;
    localparam int PHASE_COUNT    = 8;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_OFF_CYCLES = 300;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    // [11:0] eye_a_x, [23:12] eye_b_x, [35:24] nose_x, [47:36] nose_y
    logic [TDATA_W-1:0]       s_axis_tdata;
    // [1:0] action, [2] one_face
    logic [2:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    // [2:0] outcome, [6:3] swings_x, [10:7] swings_y, [15:11] zero
    logic [RES_W-1:0]         m_axis_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    int   mismatches;
    int   results_awaited;
    int   requests_sent = 0;
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    int   hold_left     = 0;
    logic hold_request  = 1'b0;

    head_nod_shake_detector_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // The checker sits beside the block, watching both streams and the
    // register port, and reports its failure count back to this module.
    hnsd_outcome_checker #(
        .COORD_BITS (COORD_BITS),
        .TDATA_W    (TDATA_W)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_awaited (results_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Overall watchdog. It is far beyond the slowest legal run, so reaching
    // it means the block has stopped answering requests.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result receiver. It normally stalls at the rate chosen for the phase,
    // but on request it holds tready low for a long stretch of its own so
    // that the block fills up and pushes back on the request side.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    // Offers one request and returns at the edge where it is taken. The
    // valid line is left high, so a request that follows at once keeps it
    // up; only when a gap is drawn is it dropped for some cycles.
    task automatic offer_request(input logic [1:0] act, input logic face,
                                 input int ea, input int eb, input int nx, input int ny);
        if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({clamp_coord(ny), clamp_coord(nx),
                                   clamp_coord(eb), clamp_coord(ea)});
        s_axis_tuser  <= {face, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Drops the request line and waits until every predicted result has
    // come back, plus a few cycles for the pipeline to settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_awaited != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes only happen with the block idle, hence the drain.
    task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_detector(input logic [15:0] thr, input logic [3:0] dirs,
                                input logic [7:0] ticks, input logic reject);
        write_register(hnsd_pkg::REG_MIN_DISTANCE, DATA_W'(thr));
        write_register(hnsd_pkg::REG_MIN_DIRS, DATA_W'(dirs));
        write_register(hnsd_pkg::REG_TIMEOUT, DATA_W'(ticks));
        write_register(hnsd_pkg::REG_FAIL_SAFE, DATA_W'(reject));
    endtask

    // One detection attempt: a restart followed by frames in which the nose
    // swings back and forth on one axis, both, or neither, with a few ticks,
    // frames without a single face and malformed requests mixed in.
    task automatic run_gesture();
        int   span;
        int   mid_x;
        int   mid_y;
        int   amp;
        int   frames;
        int   axis;
        int   sgn;
        int   roll;
        int   wobble;
        int   dx;
        int   dy;
        int   k;
        logic face;
        span   = $urandom_range(800, 40);
        mid_x  = $urandom_range(COORD_MAX, 0);
        mid_y  = $urandom_range(COORD_MAX, 0);
        amp    = $urandom_range(span / 3, 1);
        frames = $urandom_range(24, 3);
        axis   = $urandom_range(3, 0);
        sgn    = 1;
        offer_request(hnsd_pkg::ACT_RESTART, 1'($urandom_range(1, 0)),
                      $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                      $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
        for (k = 0; k < frames; k++)
        begin
            roll   = $urandom_range(99, 0);
            wobble = $urandom_range(6, 0) - 3;
            if (roll < 5)
            begin
                // Noise: any request kind with arbitrary landmarks.
                offer_request(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                              $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                              $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
            end
            else if (roll < 13)
            begin
                offer_request(hnsd_pkg::ACT_TICK, 1'b1, mid_x, mid_x, mid_y, mid_y);
            end
            else
            begin
                face = (roll >= 17);
                dx   = (axis == 0 || axis == 2) ? sgn * amp : 0;
                dy   = (axis == 1 || axis == 2) ? sgn * amp : 0;
                offer_request(hnsd_pkg::ACT_FRAME, face, mid_x + span / 2 + wobble,
                              mid_x - span / 2, mid_x + dx + wobble, mid_y + dy - wobble);
                sgn = -sgn;
            end
        end
    endtask

    // Main stimulus.
    initial
    begin
        int phase;
        int target;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, first with the registers at their reset values.
        // A large swing right, then left, reaches two swings on x and aborts.
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 300, 100, 2000, 2000);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 300, 100, 2100, 2000);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 300, 100, 2000, 2000);
        // Once decided, frames and ticks leave everything as it is.
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 300, 100, 2100, 2000);
        offer_request(hnsd_pkg::ACT_TICK, 1'b1, 0, 0, 0, 0);
        // Four ticks after a restart time out and reject.
        offer_request(hnsd_pkg::ACT_RESTART, 1'b0, 0, 0, 0, 0);
        repeat (4)
            offer_request(hnsd_pkg::ACT_TICK, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX);
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        // A frame without a single face is ignored.
        offer_request(hnsd_pkg::ACT_FRAME, 1'b0, COORD_MAX, 0, COORD_MAX, 0);
        // Reversed eyes give a negative span, so the sum is clamped.
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 0, COORD_MAX, 0, 0);
        // Full-scale vertical travel down and back up confirms a nod.
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, COORD_MAX, 0, 0, COORD_MAX);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, COORD_MAX, 0, 0, 0);
        offer_request(ACT_UNUSED, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // A still nose is never a swing.
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 200, 100, 1000, 1000);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 200, 100, 1000, 1000);

        // With no swings needed, the first frame aborts on x at once.
        set_detector(16'd0, 4'd0, 8'd10, 1'b1);
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 600, 500, 2000, 2000);
        // A zero timeout makes a restart time out immediately, here accepting.
        set_detector(16'hFFFF, 4'd1, 8'd0, 1'b0);
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 600, 500, 2000, 2000);
        // A zero threshold turns a single pixel of travel into a swing.
        set_detector(16'd0, 4'd1, 8'd4, 1'b1);
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 600, 500, 2000, 2000);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 600, 500, 2001, 2000);
        // Timeout lowered below the elapsed count while running: the next
        // frame times out instead of being evaluated.
        offer_request(hnsd_pkg::ACT_RESTART, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_TICK, 1'b1, 0, 0, 0, 0);
        offer_request(hnsd_pkg::ACT_TICK, 1'b1, 0, 0, 0, 0);
        write_register(hnsd_pkg::REG_TIMEOUT, 32'd1);
        offer_request(hnsd_pkg::ACT_FRAME, 1'b1, 600, 500, 2000, 2000);

        // Random phases, each with its own register settings and idling.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_detector(16'd96, 4'd2, 8'd40, 1'b1);
                1: set_detector(16'd0, 4'd15, 8'd255, 1'b0);
                2: set_detector(16'hFFFF, 4'd1, 8'd20, 1'b1);
                3: set_detector(16'd160, 4'd0, 8'd10, 1'b0);
                4: set_detector(16'd48, 4'd3, 8'd0, 1'b1);
                default:
                    set_detector(($urandom_range(9, 0) == 0) ? 16'd0 :
                                 ($urandom_range(9, 0) == 0) ? 16'hFFFF :
                                 16'($urandom_range(400, 16)),
                                 ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0)) :
                                 4'($urandom_range(4, 1)),
                                 ($urandom_range(7, 0) == 0) ? 8'($urandom_range(5, 0)) :
                                 8'($urandom_range(255, 12)),
                                 1'($urandom_range(1, 0)));
            endcase
            case (phase % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 57;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 57;
                end
                default:
                begin
                    src_idle_pct  = 35;
                    snk_stall_pct = 35;
                end
            endcase
            // In the first phase the receiver stops for a long stretch while
            // requests keep coming, so the block must stall its input.
            if (phase == 0)
                hold_request = 1'b1;
            target = requests_sent + PHASE_REQUESTS / 2;
            while (requests_sent < target)
                run_gesture();
            // Half way through, the sender waits for every result.
            drain_results();
            target = requests_sent + PHASE_REQUESTS / 2;
            while (requests_sent < target)
                run_gesture();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && results_awaited == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
